[hdl/bhpq_pkg.sv]
// Shared types, codes and the order compare for the binary heap priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package bhpq_pkg;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

	typedef enum logic [1:0] {
		RES_INSERT  = 2'd0,
		RES_FULL    = 2'd1,
		RES_EMPTY   = 2'd2,
		RES_EXTRACT = 2'd3
	} res_kind_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_UP_RD  = 6'b000010,
		ST_UP_CMP = 6'b000100,
		ST_EX_LD  = 6'b001000,
		ST_DN_RD  = 6'b010000,
		ST_DN_CMP = 6'b100000
	} state_t;

	typedef struct packed {
		logic      ins_begin;
		logic      ext_read;
		logic      ext_load;
		logic      rd_parent;
		logic      rd_children;
		logic      move_up;
		logic      move_down;
		logic      place;
		logic      emit;
		res_kind_t kind;
	} bhpq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic cnt_one;
		logic pos_zero;
		logic up_beats;
		logic dn_sel;
	} bhpq_stat_t;

	// True when a must sit above b: mode 0 is a max-heap, mode 1 a min-heap.
	function automatic logic bhpq_beats(input logic mode, input logic signed [31:0] a,
			input logic signed [31:0] b);
		return mode ? (a < b) : (a > b);
	endfunction

endpackage

[hdl/bhpq_ctrl.sv]
// Controller state machine of the binary heap priority queue.
// Depends on bhpq_pkg; drives commands into bhpq_dp and reads its status.
module bhpq_ctrl import bhpq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       op,
	input  bhpq_stat_t stat,
	output bhpq_cmd_t  cmd,
	output logic       busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_INSERT) begin
						if (stat.full) begin
							cmd.emit = 1'b1;
							cmd.kind = RES_FULL;
						end else begin
							cmd.ins_begin = 1'b1;
							state_d       = ST_UP_RD;
						end
					end else begin
						if (stat.empty) begin
							cmd.emit = 1'b1;
							cmd.kind = RES_EMPTY;
						end else begin
							cmd.ext_read = 1'b1;
							state_d      = ST_EX_LD;
						end
					end
				end
			end
			ST_UP_RD: begin
				if (stat.pos_zero) begin
					cmd.place = 1'b1;
					cmd.emit  = 1'b1;
					cmd.kind  = RES_INSERT;
					state_d   = ST_IDLE;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				if (stat.up_beats) begin
					cmd.move_up = 1'b1;
					state_d     = ST_UP_RD;
				end else begin
					cmd.place = 1'b1;
					cmd.emit  = 1'b1;
					cmd.kind  = RES_INSERT;
					state_d   = ST_IDLE;
				end
			end
			ST_EX_LD: begin
				cmd.ext_load = 1'b1;
				if (stat.cnt_one) begin
					cmd.emit = 1'b1;
					cmd.kind = RES_EXTRACT;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_DN_RD;
				end
			end
			ST_DN_RD: begin
				cmd.rd_children = 1'b1;
				state_d         = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				if (stat.dn_sel) begin
					cmd.move_down = 1'b1;
					state_d       = ST_DN_RD;
				end else begin
					cmd.place = 1'b1;
					cmd.emit  = 1'b1;
					cmd.kind  = RES_EXTRACT;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[hdl/bhpq_dp.sv]
// Datapath of the binary heap priority queue: entry memory, fill count, sift registers.
// Depends on bhpq_pkg; executes the commands of bhpq_ctrl and returns status.
module bhpq_dp import bhpq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               order_mode_we,
	input  logic               order_mode_wdata,
	input  logic signed [31:0] value,
	input  bhpq_cmd_t          cmd,
	output bhpq_stat_t         stat,
	output logic               done,
	output logic signed [31:0] root_value,
	output logic [1:0]         status,
	output logic [6:0]         entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = AW + 2;

	logic signed [31:0] mem [CAPACITY];

	logic               order_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      pos_q;
	logic signed [31:0] v_q;
	logic signed [31:0] root_q;
	logic signed [31:0] rd_a_q;
	logic signed [31:0] rd_b_q;
	logic               done_q;
	logic signed [31:0] res_value_q;
	logic [1:0]         res_status_q;

	logic [AW-1:0]      parent;
	logic [PW-1:0]      left_w;
	logic [PW-1:0]      right_w;
	logic [PW-1:0]      cnt_w;
	logic               left_ok;
	logic               right_ok;
	logic               left_win;
	logic               right_win;
	logic signed [31:0] best_data;
	logic [AW-1:0]      best_pos;
	logic               rd_en;
	logic [AW-1:0]      addr_a;
	logic [AW-1:0]      addr_b;
	logic               we;
	logic signed [31:0] wdata;
	logic [CW+6:0]      count_ext;

	assign parent    = (pos_q - AW'(1)) >> 1;
	assign left_w    = {1'b0, pos_q, 1'b1};
	assign right_w   = left_w + PW'(1);
	assign cnt_w     = PW'(count_q);
	assign left_ok   = left_w < cnt_w;
	assign right_ok  = right_w < cnt_w;
	assign left_win  = left_ok && bhpq_beats(order_q, rd_a_q, v_q);
	assign right_win = right_ok && bhpq_beats(order_q, rd_b_q, left_win ? rd_a_q : v_q);
	assign best_data = right_win ? rd_b_q : rd_a_q;
	assign best_pos  = right_win ? right_w[AW-1:0] : left_w[AW-1:0];

	assign stat.full     = (count_q == CW'(CAPACITY));
	assign stat.empty    = (count_q == '0);
	assign stat.cnt_one  = (count_q == CW'(1));
	assign stat.pos_zero = (pos_q == '0);
	assign stat.up_beats = bhpq_beats(order_q, v_q, rd_a_q);
	assign stat.dn_sel   = left_win || right_win;

	always_comb begin
		rd_en  = cmd.ext_read || cmd.rd_parent || cmd.rd_children;
		addr_a = '0;
		addr_b = AW'(count_q - CW'(1));
		if (cmd.rd_parent) begin
			addr_a = parent;
		end else if (cmd.rd_children) begin
			addr_a = left_w[AW-1:0];
			addr_b = right_w[AW-1:0];
		end
	end

	assign we    = cmd.move_up || cmd.move_down || cmd.place;
	assign wdata = cmd.move_up ? rd_a_q : (cmd.move_down ? best_data : v_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[pos_q] <= wdata;
		end
		if (rd_en) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_begin) begin
			pos_q <= AW'(count_q);
			v_q   <= value;
		end else if (cmd.ext_load) begin
			pos_q  <= '0;
			v_q    <= rd_b_q;
			root_q <= rd_a_q;
		end else if (cmd.move_up) begin
			pos_q <= parent;
		end else if (cmd.move_down) begin
			pos_q <= best_pos;
		end
		if (cmd.emit) begin
			case (cmd.kind)
				RES_INSERT: begin
					res_value_q  <= '0;
					res_status_q <= STATUS_OK;
				end
				RES_FULL: begin
					res_value_q  <= '0;
					res_status_q <= STATUS_FULL;
				end
				RES_EMPTY: begin
					res_value_q  <= EMPTY_VALUE;
					res_status_q <= STATUS_EMPTY;
				end
				RES_EXTRACT: begin
					res_value_q  <= cmd.ext_load ? rd_a_q : root_q;
					res_status_q <= STATUS_OK;
				end
				default: begin
					res_value_q  <= '0;
					res_status_q <= STATUS_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (order_mode_we) begin
				order_q <= order_mode_wdata;
			end
			if (cmd.ins_begin) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.ext_load) begin
				count_q <= count_q - CW'(1);
			end
			done_q <= cmd.emit;
		end
	end

	assign count_ext   = {7'b0, count_q};
	assign done        = done_q;
	assign root_value  = res_value_q;
	assign status      = res_status_q;
	assign entry_count = count_ext[6:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.kind == RES_FULL) |-> stat.full)
		else $error("full status while the heap has room");

	a_down_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move_down |-> left_ok)
		else $error("sift-down moved to a child beyond the last entry");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_begin |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not advance the fill count");

endmodule

[hdl/binary_heap_priority_queue_unit.sv]
// Top level of the binary heap priority queue: controller and datapath.
// Depends on bhpq_pkg, bhpq_ctrl and bhpq_dp.
//
// One operation at a time: start is taken when busy is low, and each operation gives
// exactly one word on root_value, status and entry_count, marked by done for a single
// cycle; the receiver cannot stall it. A full insert or an empty extract keeps busy low
// and gives done in the next cycle. Otherwise busy stays high while an insert moves the
// new value up from the end, or an extract takes the root and, unless it was the last
// entry, moves the last entry down from the root; done follows in the next cycle. The
// value moves at most log2 of CAPACITY levels, each with a registered read of the entry
// memory and then a compare and write. The next start may be given in the cycle done is
// high. The user must write order_mode only while idle; the block does not enforce it.
module binary_heap_priority_queue_unit import bhpq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               order_mode_we,
	input  logic               order_mode_wdata,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] root_value,
	output logic [1:0]         status,
	output logic [6:0]         entry_count
);

	bhpq_cmd_t  cmd;
	bhpq_stat_t stat;
	logic       accept;

	assign accept = start && !busy;

	bhpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	bhpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.order_mode_we    (order_mode_we),
		.order_mode_wdata (order_mode_wdata),
		.value            (value),
		.cmd              (cmd),
		.stat             (stat),
		.done             (done),
		.root_value       (root_value),
		.status           (status),
		.entry_count      (entry_count)
	);

endmodule
